>>> sv/maes_pkg.sv
// Package with constants, tables and round functions of the masked AES-128 engine.
`default_nettype none
package maes_pkg;

  localparam int unsigned BLOCK_W = 128;
  localparam int unsigned HALF_W  = 64;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned NUM_ROUNDS = 10;

  typedef logic [BLOCK_W-1:0]   block_t;
  typedef logic [HALF_W-1:0]    half_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [7:0]           byte_t;
  typedef logic [31:0]          word_t;

  localparam cfg_idx_t CFG_KEY_HIGH   = 8'd0;
  localparam cfg_idx_t CFG_KEY_LOW    = 8'd1;
  localparam cfg_idx_t CFG_SBOX_MASKS = 8'd2;
  localparam cfg_idx_t CFG_ROW_MASKS  = 8'd3;

  localparam byte_t RCON [NUM_ROUNDS] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Mask set shared by every round: M, M', row masks and their column images.
  typedef struct packed {
    byte_t m;
    byte_t mp;
    word_t rm;
    word_t cm;
  } mask_set_t;

  // Byte 0 is the most significant byte of a block.
  function automatic byte_t get_byte(input block_t v, input int unsigned i);
    get_byte = v[BLOCK_W-1-8*i -: 8];
  endfunction

  function automatic byte_t word_byte(input word_t w, input int unsigned i);
    word_byte = w[31-8*i -: 8];
  endfunction

  function automatic byte_t xtime(input byte_t a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic word_t mix_col(input word_t c);
    byte_t a0, a1, a2, a3;
    a0 = c[31:24];
    a1 = c[23:16];
    a2 = c[15:8];
    a3 = c[7:0];
    mix_col = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
               a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
               a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
               xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  function automatic byte_t msub(input byte_t x, input mask_set_t ms);
    msub = SBOX[x ^ ms.m] ^ ms.mp;
  endfunction

  function automatic block_t shift_rows(input block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BLOCK_W-1-8*(r+4*c) -: 8] = get_byte(s, r + 4*((c + r) % 4));
      end
    end
    shift_rows = t;
  endfunction

  // Key schedule core: rotated, masked substitution of the last word.
  function automatic word_t key_core(input block_t k, input byte_t rc, input mask_set_t ms);
    key_core = {msub(get_byte(k, 13) ^ word_byte(ms.cm, 1), ms) ^ rc,
                msub(get_byte(k, 14) ^ word_byte(ms.cm, 2), ms),
                msub(get_byte(k, 15) ^ word_byte(ms.cm, 3), ms),
                msub(get_byte(k, 12) ^ word_byte(ms.cm, 0), ms)};
  endfunction

  function automatic block_t key_mid(input block_t k, input byte_t rc, input mask_set_t ms);
    byte_t o [16];
    word_t t;
    block_t r;
    t = key_core(k, rc, ms);
    r = '0;
    for (int j = 0; j < 4; j++) o[j] = get_byte(k, j) ^ word_byte(t, j) ^ ms.mp;
    for (int j = 4; j < 16; j++) begin
      o[j] = get_byte(k, j) ^ ms.m ^ o[j-4] ^ word_byte(ms.cm, j % 4);
    end
    for (int j = 0; j < 16; j++) r[BLOCK_W-1-8*j -: 8] = o[j];
    key_mid = r;
  endfunction

  function automatic block_t key_last(input block_t k, input byte_t rc, input mask_set_t ms);
    byte_t o [16];
    word_t t;
    block_t r;
    t = key_core(k, rc, ms);
    r = '0;
    for (int j = 0; j < 4; j++) o[j] = get_byte(k, j) ^ word_byte(t, j);
    for (int j = 4; j < 8; j++) o[j] = get_byte(k, j) ^ o[j-4];
    for (int j = 8; j < 16; j++) begin
      o[j] = get_byte(k, j) ^ word_byte(ms.cm, j % 4) ^ o[j-4];
    end
    for (int j = 0; j < 4; j++) o[j] = o[j] ^ word_byte(ms.cm, j) ^ ms.m;
    for (int j = 8; j < 12; j++) o[j] = o[j] ^ ms.m;
    for (int j = 0; j < 16; j++) r[BLOCK_W-1-8*j -: 8] = o[j];
    key_last = r;
  endfunction

  function automatic block_t sub_bytes(input block_t s, input block_t k, input mask_set_t ms);
    block_t r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[BLOCK_W-1-8*i -: 8] = msub(get_byte(s, i) ^ get_byte(k, i), ms);
    end
    sub_bytes = r;
  endfunction

  // Full middle round: key add, S-box, ShiftRows, remask to row masks, MixColumns.
  function automatic block_t round_mid(input block_t s, input block_t k, input mask_set_t ms);
    block_t t;
    block_t r;
    t = shift_rows(sub_bytes(s, k, ms));
    r = '0;
    for (int i = 0; i < 16; i++) begin
      t[BLOCK_W-1-8*i -: 8] = get_byte(t, i) ^ ms.mp ^ word_byte(ms.rm, i % 4);
    end
    for (int c = 0; c < 4; c++) r[BLOCK_W-1-32*c -: 32] = mix_col(t[BLOCK_W-1-32*c -: 32]);
    round_mid = r;
  endfunction

endpackage
`default_nettype wire

>>> sv/maes_if.sv
// Handshake interfaces for the plaintext, ciphertext and configuration channels.
`default_nettype none
interface maes_plain_if;
  logic valid;
  logic ready;
  logic [63:0] plain_high;
  logic [63:0] plain_low;
  modport source (output valid, output plain_high, output plain_low, input ready);
  modport sink   (input valid, input plain_high, input plain_low, output ready);
endinterface

interface maes_cipher_if;
  logic valid;
  logic ready;
  logic [63:0] cipher_high;
  logic [63:0] cipher_low;
  modport source (output valid, output cipher_high, output cipher_low, input ready);
  modport sink   (input valid, input cipher_high, input cipher_low, output ready);
endinterface

interface maes_cfg_if;
  logic valid;
  logic ready;
  logic [7:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> sv/masked_aes128_block_encrypt.sv
// Top level of the pipelined, first-order masked AES-128 encryption engine.
//
// The plaintext channel takes one 128-bit block per transfer; the ciphertext
// channel returns one block per plaintext, in order. The configuration channel
// writes the key halves, the S-box masks and the row masks; it is always ready
// and should only be written while no block is in flight.
//
// The datapath is an eleven-stage pipeline: stage 0 applies the input masks
// and forms the masked first round key, stages 1 to 9 each hold one full
// round together with one step of the on-the-fly key schedule, and stage 10
// does the last round and removes the masks. Stage 0 is loaded at the input
// transfer edge and the last stage register is the output register, which
// drives the output valid and the result. Throughput is one block per cycle
// while the receiver does not stall.
//
// When the receiver stalls with a valid result, the whole pipeline holds and
// the input ready drops; nothing is lost or repeated. Bubbles are carried as
// invalid stages. Synchronous reset clears all valid bits and the
// configuration registers to zero.
`default_nettype none
module masked_aes128_block_encrypt (
  input  wire logic     clk,
  input  wire logic     rst,
  maes_cfg_if.sink      cfg,
  maes_plain_if.sink    plain,
  maes_cipher_if.source cipher
);
  import maes_pkg::*;

  localparam int unsigned NSTAGE = NUM_ROUNDS + 1;

  half_t key_high;
  half_t key_low;
  logic [15:0] sbox_masks;
  word_t row_masks;

  // The configuration port never pushes back.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high   <= '0;
      key_low    <= '0;
      sbox_masks <= '0;
      row_masks  <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_KEY_HIGH:   key_high   <= cfg.data;
        CFG_KEY_LOW:    key_low    <= cfg.data;
        CFG_SBOX_MASKS: sbox_masks <= cfg.data[15:0];
        CFG_ROW_MASKS:  row_masks  <= cfg.data[31:0];
        default: ;
      endcase
    end
  end

  // Keep masks fixed while blocks are in flight (unchecked); every stage reads them.
  mask_set_t ms;
  always_comb begin
    ms.m  = sbox_masks[15:8];
    ms.mp = sbox_masks[7:0];
    ms.rm = row_masks;
    ms.cm = mix_col(row_masks);
  end

  block_t st   [NSTAGE];
  block_t rk   [NSTAGE-1];
  logic   vld  [NSTAGE];
  logic   adv;

  // The pipeline moves as a whole whenever the output register is free or drained.
  assign adv         = !vld[NSTAGE-1] || cipher.ready;
  assign plain.ready = adv;

  // Stage 0: mask the plaintext with the column masks and the key with them and M.
  block_t st0_next;
  block_t rk0_next;
  always_comb begin
    block_t pin;
    block_t kin;
    pin = {plain.plain_high, plain.plain_low};
    kin = {key_high, key_low};
    st0_next = '0;
    rk0_next = '0;
    for (int i = 0; i < 16; i++) begin
      st0_next[BLOCK_W-1-8*i -: 8] = get_byte(pin, i) ^ word_byte(ms.cm, i % 4);
      rk0_next[BLOCK_W-1-8*i -: 8] = get_byte(kin, i) ^ word_byte(ms.cm, i % 4) ^ ms.m;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= plain.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= st0_next;
      rk[0] <= rk0_next;
    end
  end

  // Stages 1 to 9: one middle round and one key schedule step each.
  for (genvar g = 1; g < NSTAGE - 1; g++) begin : g_round
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (adv) begin
        vld[g] <= vld[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[g] <= round_mid(st[g-1], rk[g-1], ms);
        rk[g] <= key_mid(rk[g-1], RCON[g-1], ms);
      end
    end
  end

  // Stage 10: last round; the last round key carries M', which cancels the state mask.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[NSTAGE-1] <= 1'b0;
    end else if (adv) begin
      vld[NSTAGE-1] <= vld[NSTAGE-2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[NSTAGE-1] <= shift_rows(sub_bytes(st[NSTAGE-2], rk[NSTAGE-2], ms))
                      ^ key_last(rk[NSTAGE-2], RCON[NUM_ROUNDS-1], ms);
    end
  end

  assign cipher.valid       = vld[NSTAGE-1];
  assign cipher.cipher_high = st[NSTAGE-1][BLOCK_W-1 -: HALF_W];
  assign cipher.cipher_low  = st[NSTAGE-1][HALF_W-1:0];

endmodule
`default_nettype wire

>>> sv/maes_checker.sv
// Port-level checker for the masked AES engine and its bind statement.
`default_nettype none
module maes_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        cfg_ready,
  input wire logic [63:0] out_high
);
  // A pending result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps the value of its upper half.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_high))
    else $error("result changed while stalled");

  // With no result waiting the engine takes input.
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // Reset leaves no result behind, and configuration is always taken.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && cfg_ready)
    else $error("output valid after reset");
endmodule

bind masked_aes128_block_encrypt maes_checker u_maes_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (plain.ready),
  .out_valid (cipher.valid),
  .out_ready (cipher.ready),
  .cfg_ready (cfg.ready),
  .out_high  (cipher.cipher_high)
);
`default_nettype wire

>>> dv/masked_aes128_block_encrypt_test.sv
// Self-checking test of the masked AES-128 engine against a plain AES-128 predictor.
`default_nettype none
module masked_aes128_block_encrypt_test;
  import maes_pkg::*;

  // The masked engine must always produce standard AES-128 ciphertext, so the
  // predictor below is an ordinary unmasked AES-128 that ignores the masks.
  typedef logic [127:0] aes_block_t;

  function automatic logic [7:0] gf_double(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic aes_block_t aes128_encrypt(input aes_block_t key, input aes_block_t pt);
    logic [7:0] st [16];
    logic [7:0] rk [16];
    logic [7:0] tmp [16];
    logic [7:0] w [4];
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] rcon;
    aes_block_t res;
    rcon = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127-8*i -: 8];
      st[i] = pt[127-8*i -: 8] ^ rk[i];
    end
    for (int r = 1; r <= 10; r++) begin
      // Next round key.
      w[0] = SBOX[rk[13]] ^ rcon;
      w[1] = SBOX[rk[14]];
      w[2] = SBOX[rk[15]];
      w[3] = SBOX[rk[12]];
      for (int j = 0; j < 4; j++) rk[j] = rk[j] ^ w[j];
      for (int j = 4; j < 16; j++) rk[j] = rk[j] ^ rk[j-4];
      rcon = gf_double(rcon);
      // SubBytes and ShiftRows.
      for (int c = 0; c < 4; c++)
        for (int q = 0; q < 4; q++) tmp[q + 4*c] = SBOX[st[q + 4*((c + q) % 4)]];
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = tmp[4*c]; a1 = tmp[4*c+1]; a2 = tmp[4*c+2]; a3 = tmp[4*c+3];
          tmp[4*c]   = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
          tmp[4*c+1] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
          tmp[4*c+2] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
          tmp[4*c+3] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ rk[i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  // Scoreboard: holds ciphertexts expected in order and counts mismatches.
  class cipher_scoreboard;
    aes_block_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function void note_plain(aes_block_t key, aes_block_t pt);
      pending.push_back(aes128_encrypt(key, pt));
    endfunction

    function void check_cipher(logic [63:0] hi, logic [63:0] lo);
      aes_block_t exp_blk;
      if (pending.size() == 0) begin
        $display("%0t: unexpected ciphertext %h_%h", $time, hi, lo);
        errors++;
        return;
      end
      exp_blk = pending.pop_front();
      if (hi !== exp_blk[127:64]) begin
        $display("%0t: cipher_high expected %h actual %h", $time, exp_blk[127:64], hi);
        errors++;
      end
      if (lo !== exp_blk[63:0]) begin
        $display("%0t: cipher_low expected %h actual %h", $time, exp_blk[63:0], lo);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY = 11;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst;
  maes_cfg_if    cfg ();
  maes_plain_if  plain ();
  maes_cipher_if cipher ();

  masked_aes128_block_encrypt dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg.sink),
    .plain  (plain.sink),
    .cipher (cipher.source)
  );

  cipher_scoreboard sb;
  // Shadow of the key registers; the masks do not affect the ciphertext and are
  // not shadowed, but they are written so every register write is exercised.
  logic [63:0] key_hi_shadow, key_lo_shadow;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one, sometimes none at all.
  function automatic int gap_length();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // A transfer on any channel resets the watchdog.
  always @(posedge clk) begin
    if (rst || (plain.valid && plain.ready) || (cipher.valid && cipher.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Results are checked at the rising edge where the transfer happens.
  always @(posedge clk) begin
    if (!rst && cipher.valid && cipher.ready) sb.check_cipher(cipher.cipher_high, cipher.cipher_low);
  end

  // Receiver: random back-pressure, changed at the falling edge.
  initial begin
    int stall;
    cipher.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = gap_length();
      if (stall == 0) begin
        cipher.ready <= 1'b1;
        @(negedge clk);
      end else begin
        cipher.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // One register write; the key shadow is updated once the transfer completes.
  // The valid drops for one cycle before the task returns.
  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
    cfg.index <= idx;
    cfg.data  <= value;
    cfg.valid <= 1'b1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    if (idx == CFG_KEY_HIGH) key_hi_shadow = value;
    else if (idx == CFG_KEY_LOW) key_lo_shadow = value;
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Sends one plaintext and notes its expected ciphertext on acceptance.
  // Without hold_valid the valid drops for one cycle before the task returns.
  task automatic send_plain(input logic [63:0] hi, input logic [63:0] lo, input bit hold_valid);
    plain.plain_high <= hi;
    plain.plain_low  <= lo;
    plain.valid      <= 1'b1;
    @(posedge clk);
    while (!plain.ready) @(posedge clk);
    sb.note_plain({key_hi_shadow, key_lo_shadow}, {hi, lo});
    @(negedge clk);
    if (!hold_valid) begin
      plain.valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Waits until every expected ciphertext has arrived, then lets the
  // pipeline drain before anything is reconfigured.
  task automatic drain();
    plain.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  // Random plaintexts, with field extremes mixed in.
  function automatic logic [63:0] rand_half();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 64'h0;
    if (sel == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_traffic(input int count);
    int gap;
    for (int n = 0; n < count; n++) begin
      gap = gap_length();
      send_plain(rand_half(), rand_half(), gap == 0);
      if (gap != 0) repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic configure(input logic [63:0] kh, input logic [63:0] kl,
                           input logic [63:0] sm, input logic [63:0] rm);
    write_reg(CFG_KEY_HIGH, kh);
    write_reg(CFG_KEY_LOW, kl);
    write_reg(CFG_SBOX_MASKS, sm);
    write_reg(CFG_ROW_MASKS, rm);
  endtask

  initial begin
    sb = new();
    key_hi_shadow = '0;
    key_lo_shadow = '0;
    rst = 1'b1;
    plain.valid = 1'b0;
    plain.plain_high = '0;
    plain.plain_low = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Registers at their reset values: all-zero key and masks.
    send_plain(64'h0, 64'h0, 1'b0);
    send_plain('1, '1, 1'b0);
    drain();

    // Standard test vector with zero masks, then its plaintext under an all-ones
    // key and full masks; bits above the mask widths are set to show they are ignored.
    configure(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 64'hffff_ffff_ffff_0000,
              64'hffff_ffff_0000_0000);
    send_plain(64'h3243f6a8885a308d, 64'h313198a2e0370734, 1'b1);
    send_plain(64'h00112233_44556677, 64'h8899aabb_ccddeeff, 1'b0);
    drain();
    configure('1, '1, 64'hffff, 64'hffffffff);
    send_plain(64'h3243f6a8885a308d, 64'h313198a2e0370734, 1'b1);
    send_plain(64'h0, '1, 1'b1);
    send_plain('1, 64'h0, 1'b0);
    drain();
    // Writes to indexes past the last register must have no effect.
    cfg.index <= 8'd4;
    cfg.data  <= {$urandom(), $urandom()};
    cfg.valid <= 1'b1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.index <= 8'hff;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
    send_plain(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
    drain();

    // Random phases, each under a fresh random key and mask setting.
    for (int ph = 0; ph < 5; ph++) begin
      configure({$urandom(), $urandom()}, {$urandom(), $urandom()},
                {$urandom(), $urandom()}, {$urandom(), $urandom()});
      random_traffic(100);
      drain();
    end

    repeat (LATENCY + 4) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
